// ===== rtl/tbah_pkg.sv =====
// ----------------------------------------------------------------------------
// tbah_pkg
// Shared beat types, command and status bundles and constants for the
// time-bucket activity histogram.
// ----------------------------------------------------------------------------
package tbah_pkg;

    // Width of a day, week or month bucket id held in an anchor.
    localparam int ID_W = 31;

    // Action codes carried in the input beat.
    localparam logic [1:0] ACT_RECORD  = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    // Window selector codes for a read.
    localparam logic [1:0] SEL_DAY   = 2'd0;
    localparam logic [1:0] SEL_WEEK  = 2'd1;
    localparam logic [1:0] SEL_MONTH = 2'd2;

    // Counter saturation value and week arithmetic.
    localparam logic [7:0] SAT_MAX     = 8'd255;
    localparam int         WEEK_OFFSET = 3;
    localparam int         WEEK_LEN    = 7;

    // Reciprocal of the week length scaled by 2^35, less its 2^32 term.
    // The week id is worked out as the product, then the quotient.
    localparam logic [29:0] WEEK_RECIP = 30'h24924925;
    localparam int          DIV_STEPS  = 2;

    typedef struct packed {
        logic [1:0]  action;
        logic [30:0] day_index;
        logic [30:0] month_index;
        logic        kind;
        logic [1:0]  window_select;
        logic [3:0]  slot;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]         solo_count;
        logic [7:0]         partner_count;
        logic signed [31:0] bucket_id;
        logic               dropped;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step_clr;
        logic step_inc;
        logic div_step;
        logic prep;
        logic shift;
        logic rot;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_move;
        logic is_read;
        logic is_record;
        logic div_last;
        logic shift_busy;
        logic rot_last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/time_bucket_activity_histogram.sv =====
// ----------------------------------------------------------------------------
// time_bucket_activity_histogram
// Rolling solo/partner event counters over day, week and month windows.
//
// Input channel (i_valid, o_stall, i_data) takes one action beat: record an
// event, advance the windows, or read one bucket. Output channel (o_valid,
// i_stall, o_data) returns exactly one result beat per action.
// One action is worked at a time. A read rotates every window bank once
// around to reach the chosen bucket; an advance computes the week id by
// reciprocal multiplication and shifts each bank to fill the gap; a record
// does both, counting the event during the rotation; an unknown action goes
// straight to the output. Each window bank moves one slot per cycle for the
// gap fill and for the full rotation, which runs over the deepest window
// (14 slots by default).
// The next beat is accepted in the cycle after the result enters the output
// register, so a stalled receiver holds up at most one finished beat.
// Reset clears all anchors and counters at once; no beat is in flight after.
// ----------------------------------------------------------------------------
module time_bucket_activity_histogram
    import tbah_pkg::*;
#(
    parameter int DAY_SLOTS   = 14,
    parameter int WEEK_SLOTS  = 12,
    parameter int MONTH_SLOTS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    tbah_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_cmd    (cmd),
        .i_status (status)
    );

    // Windows, divider and output register.
    tbah_datapath #(
        .DAY_SLOTS   (DAY_SLOTS),
        .WEEK_SLOTS  (WEEK_SLOTS),
        .MONTH_SLOTS (MONTH_SLOTS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_data   (o_data),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

// ===== rtl/tbah_window.sv =====
// ----------------------------------------------------------------------------
// tbah_window
// One rolling window of paired 8-bit counters with its anchor. The bank
// moves one slot per cycle: a shift drops the oldest bucket and brings in
// a zero, a rotation walks every bucket past slot 0 and back into place.
// ----------------------------------------------------------------------------
module tbah_window
    import tbah_pkg::*;
#(
    parameter int N  = 14,
    parameter int SW = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_prep,
    input  logic            i_shift,
    input  logic            i_rot,
    input  logic            i_record,
    input  logic            i_kind,
    input  logic [SW-1:0]   i_step,
    input  logic [3:0]      i_slot,
    input  logic [ID_W-1:0] i_target,
    output logic [ID_W-1:0] o_anchor,
    output logic [15:0]     o_cap,
    output logic            o_hit,
    output logic            o_shift_busy
);

    localparam int CW = $clog2(N + 1);
    localparam int PW = (N > 1) ? $clog2(N) : 1;

    logic [15:0]     r_cnt [N];
    logic [15:0]     n_cnt [N];
    logic [ID_W-1:0] r_anchor, n_anchor;
    logic [CW-1:0]   r_dist, n_dist;
    logic            r_hit, n_hit;
    logic [PW-1:0]   r_pos, n_pos;
    logic [15:0]     r_cap, n_cap;

    logic signed [31:0] diff;
    logic signed [31:0] back;
    logic signed [31:0] pos_full;
    logic [7:0]         solo;
    logic [7:0]         partner;

    // Distance to the target, and the bucket position of the target once
    // the window has moved.
    assign diff     = $signed({1'b0, i_target}) - $signed({1'b0, r_anchor});
    assign back     = -diff;
    assign pos_full = $signed(32'(N - 1)) - back;

    always_comb begin
        n_cnt    = r_cnt;
        n_anchor = r_anchor;
        n_dist   = r_dist;
        n_hit    = r_hit;
        n_pos    = r_pos;
        n_cap    = r_cap;
        solo     = r_cnt[0][7:0];
        partner  = r_cnt[0][15:8];

        // Work out the move once, then let the shift phase carry it out.
        if (i_prep) begin
            if (diff > 0) begin
                n_anchor = i_target;
                n_hit    = 1'b1;
                n_pos    = PW'(N - 1);
                if (diff >= $signed(32'(N))) begin
                    n_dist = CW'(N);
                end else begin
                    n_dist = diff[CW-1:0];
                end
            end else begin
                n_dist = '0;
                n_hit  = (back < $signed(32'(N)));
                n_pos  = pos_full[PW-1:0];
            end
        end

        // Shift toward slot 0 with a zero entering at the newest end.
        if (i_shift && (i_step < SW'(r_dist))) begin
            for (int i = 0; i < N - 1; i++) begin
                n_cnt[i] = r_cnt[i + 1];
            end
            n_cnt[N-1] = 16'h0000;
        end

        // Rotate the bank once around, counting or capturing at slot 0.
        if (i_rot && (i_step < SW'(N))) begin
            if (i_record && r_hit && (i_step == SW'(r_pos))) begin
                if (i_kind) begin
                    if (partner != SAT_MAX) begin
                        partner = partner + 8'd1;
                    end
                end else begin
                    if (solo != SAT_MAX) begin
                        solo = solo + 8'd1;
                    end
                end
            end
            if (i_step == SW'(i_slot)) begin
                n_cap = r_cnt[0];
            end
            for (int i = 0; i < N - 1; i++) begin
                n_cnt[i] = r_cnt[i + 1];
            end
            n_cnt[N-1] = {partner, solo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_cnt[i] <= 16'h0000;
            end
            r_anchor <= '0;
            r_dist   <= '0;
        end else begin
            r_cnt    <= n_cnt;
            r_anchor <= n_anchor;
            r_dist   <= n_dist;
        end
        r_hit <= n_hit;
        r_pos <= n_pos;
        r_cap <= n_cap;
    end

    assign o_anchor     = r_anchor;
    assign o_cap        = r_cap;
    assign o_hit        = r_hit;
    assign o_shift_busy = (i_step < SW'(r_dist));

    // The anchor moves only when a move is being prepared.
    a_anchor_only_on_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_prep |=> $stable(r_anchor))
        else $error("window anchor changed outside the prepare step");

endmodule

// ===== rtl/tbah_datapath.sv =====
// ----------------------------------------------------------------------------
// tbah_datapath
// Input register, week divider, step counter, the three windows and the
// output register of the histogram.
// ----------------------------------------------------------------------------
module tbah_datapath
    import tbah_pkg::*;
#(
    parameter int DAY_SLOTS   = 14,
    parameter int WEEK_SLOTS  = 12,
    parameter int MONTH_SLOTS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_data,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_beat o_data,
    input  t_cmd      i_cmd,
    output t_status   o_status
);

    localparam int MAX_DW = (DAY_SLOTS > WEEK_SLOTS) ? DAY_SLOTS : WEEK_SLOTS;
    localparam int MAX_N  = (MAX_DW > MONTH_SLOTS) ? MAX_DW : MONTH_SLOTS;
    localparam int SW_N   = $clog2(MAX_N + 1);
    localparam int SW     = (SW_N > 4) ? SW_N : 4;

    // Captured input beat.
    logic [1:0]      r_action;
    logic [ID_W-1:0] r_day;
    logic [ID_W-1:0] r_month;
    logic            r_kind;
    logic [1:0]      r_sel;
    logic [3:0]      r_slot;

    logic [SW-1:0] r_step;

    // Week divider state.
    logic [31:0] r_dvd;
    logic [61:0] r_prod;
    logic [31:0] r_quo;
    logic [64:0] week_sum;

    logic            r_ovalid;
    t_out_beat       r_out, n_out;

    logic [ID_W-1:0] day_anchor, week_anchor, month_anchor;
    logic [15:0]     day_cap, week_cap, month_cap;
    logic            day_hit, week_hit, month_hit;
    logic            day_busy, week_busy, month_busy;
    logic            is_rec;

    assign is_rec = (r_action == ACT_RECORD);

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_data.action;
            r_day    <= i_data.day_index;
            r_month  <= i_data.month_index;
            r_kind   <= i_data.kind;
            r_sel    <= i_data.window_select;
            r_slot   <= i_data.slot;
        end
    end

    // Step counter shared by the divider, shift and rotate phases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.step_clr) begin
            r_step <= '0;
        end else if (i_cmd.step_inc) begin
            r_step <= r_step + SW'(1);
        end
    end

    // Week id of day plus offset by reciprocal multiplication. The full
    // reciprocal is 2^32 plus the stored part, so its top term is a plain
    // shift of the dividend. The first step forms the product and the second
    // step takes the quotient from it.
    assign week_sum = {1'b0, r_dvd, 32'h0000_0000} + {3'b000, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvd <= {1'b0, i_data.day_index} + 32'(WEEK_OFFSET);
        end else if (i_cmd.div_step) begin
            r_prod <= 62'(r_dvd) * 62'(WEEK_RECIP);
            r_quo  <= {2'b00, week_sum[64:35]};
        end
    end

    // The three windows.
    tbah_window #(.N(DAY_SLOTS), .SW(SW)) u_day (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_prep       (i_cmd.prep),
        .i_shift      (i_cmd.shift),
        .i_rot        (i_cmd.rot),
        .i_record     (is_rec),
        .i_kind       (r_kind),
        .i_step       (r_step),
        .i_slot       (r_slot),
        .i_target     (r_day),
        .o_anchor     (day_anchor),
        .o_cap        (day_cap),
        .o_hit        (day_hit),
        .o_shift_busy (day_busy)
    );

    tbah_window #(.N(WEEK_SLOTS), .SW(SW)) u_week (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_prep       (i_cmd.prep),
        .i_shift      (i_cmd.shift),
        .i_rot        (i_cmd.rot),
        .i_record     (is_rec),
        .i_kind       (r_kind),
        .i_step       (r_step),
        .i_slot       (r_slot),
        .i_target     (r_quo[ID_W-1:0]),
        .o_anchor     (week_anchor),
        .o_cap        (week_cap),
        .o_hit        (week_hit),
        .o_shift_busy (week_busy)
    );

    tbah_window #(.N(MONTH_SLOTS), .SW(SW)) u_month (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_prep       (i_cmd.prep),
        .i_shift      (i_cmd.shift),
        .i_rot        (i_cmd.rot),
        .i_record     (is_rec),
        .i_kind       (r_kind),
        .i_step       (r_step),
        .i_slot       (r_slot),
        .i_target     (r_month),
        .o_anchor     (month_anchor),
        .o_cap        (month_cap),
        .o_hit        (month_hit),
        .o_shift_busy (month_busy)
    );

    // Result of the current action.
    always_comb begin
        n_out = '0;
        unique case (r_action)
            ACT_RECORD: begin
                n_out.dropped = !(day_hit && week_hit && month_hit);
            end
            ACT_ADVANCE: begin
                n_out = '0;
            end
            ACT_READ: begin
                unique case (r_sel)
                    SEL_DAY: begin
                        if (32'(r_slot) < 32'(DAY_SLOTS)) begin
                            n_out.solo_count    = day_cap[7:0];
                            n_out.partner_count = day_cap[15:8];
                            n_out.bucket_id     = $signed({1'b0, day_anchor})
                                - $signed(32'(DAY_SLOTS - 1)) + $signed(32'(r_slot));
                        end
                    end
                    SEL_WEEK: begin
                        if (32'(r_slot) < 32'(WEEK_SLOTS)) begin
                            n_out.solo_count    = week_cap[7:0];
                            n_out.partner_count = week_cap[15:8];
                            n_out.bucket_id     = $signed({1'b0, week_anchor})
                                - $signed(32'(WEEK_SLOTS - 1)) + $signed(32'(r_slot));
                        end
                    end
                    SEL_MONTH: begin
                        if (32'(r_slot) < 32'(MONTH_SLOTS)) begin
                            n_out.solo_count    = month_cap[7:0];
                            n_out.partner_count = month_cap[15:8];
                            n_out.bucket_id     = $signed({1'b0, month_anchor})
                                - $signed(32'(MONTH_SLOTS - 1)) + $signed(32'(r_slot));
                        end
                    end
                    default: begin
                        n_out = '0;
                    end
                endcase
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // Output register: holds a finished beat until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // Status toward the controller.
    always_comb begin
        o_status            = '0;
        o_status.is_move    = (r_action == ACT_RECORD) || (r_action == ACT_ADVANCE);
        o_status.is_read    = (r_action == ACT_READ);
        o_status.is_record  = is_rec;
        o_status.div_last   = (r_step == SW'(DIV_STEPS - 1));
        o_status.shift_busy = day_busy || week_busy || month_busy;
        o_status.rot_last   = (r_step == SW'(MAX_N - 1));
        o_status.out_free   = !r_ovalid || !i_stall;
    end

    // A finished beat never overwrites one the receiver is still stalling.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || !i_stall))
        else $error("output beat overwritten while stalled");

    // The shift phase never runs past the deepest window.
    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> (r_step <= SW'(MAX_N)))
        else $error("shift phase ran past the window depth");

    // The rotate phase stays within the deepest window.
    a_rot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rot |-> (r_step < SW'(MAX_N)))
        else $error("rotate phase ran past the window depth");

endmodule

// ===== rtl/tbah_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbah_ctrl
// Sequencer of the histogram: accepts a beat, runs as the action needs the
// week division, the window move and the bank rotation, then hands off the result.
// ----------------------------------------------------------------------------
module tbah_ctrl
    import tbah_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_DIV      = 7'b0000100,
        S_PREP     = 7'b0001000,
        S_SHIFT    = 7'b0010000,
        S_ROT      = 7'b0100000,
        S_OUT      = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.step_clr = 1'b1;
                if (i_status.is_move) begin
                    n_state = S_DIV;
                end else if (i_status.is_read) begin
                    n_state = S_ROT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.step_inc = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep     = 1'b1;
                o_cmd.step_clr = 1'b1;
                n_state        = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift    = 1'b1;
                o_cmd.step_inc = 1'b1;
                if (!i_status.shift_busy) begin
                    o_cmd.step_clr = 1'b1;
                    n_state        = i_status.is_record ? S_ROT : S_OUT;
                end
            end
            S_ROT: begin
                o_cmd.rot      = 1'b1;
                o_cmd.step_inc = 1'b1;
                if (i_status.rot_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule
